// ===== src/assert_macros.svh =====
// Assertion macros shared by the integer field scanner RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== src/sfis_pkg.sv =====
// Types, codes and helper functions of the integer field scanner.
// Used by sfis_step and scanf_integer_field_scanner; depends on nothing.
`timescale 1ns / 1ps

package sfis_pkg;

  localparam int VALUE_W             = 64;
  localparam int VALUE_BITS_DEF      = 64;
  localparam int MAX_FIELD_WIDTH_DEF = 1023;
  localparam int MODE_W              = 3;
  localparam int FWIDTH_W            = 10;
  localparam int CHAR_W              = 8;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 10;
  localparam int DIGIT_W             = 5;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;

  localparam logic [DIGIT_W-1:0] NO_DIGIT = 5'd16;

  typedef enum logic [3:0] {
    PH_SPACE  = 4'b0001,
    PH_LEAD   = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_D = 3'd0,
    MODE_I = 3'd1,
    MODE_O = 3'd2,
    MODE_U = 3'd3,
    MODE_X = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    BASE_8  = 2'd0,
    BASE_10 = 2'd1,
    BASE_16 = 2'd2
  } base_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MATCH = 2'd1,
    ST_INPUT = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_WIDTH = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    phase_t phase;
    mode_t  mode;
    base_t  base;
    logic   negative;
    logic   overflowed;
    logic   has_digit;
  } ctl_t;

  typedef struct packed {
    logic    consumed;
    logic    done;
    status_t status;
    logic    out_of_range;
  } res_flags_t;

  localparam ctl_t CTL_RESET = '{
    phase:      PH_SPACE,
    mode:       MODE_D,
    base:       BASE_10,
    negative:   1'b0,
    overflowed: 1'b0,
    has_digit:  1'b0
  };

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    if (c inside {[CH_0:CH_9]}) begin
      d = DIGIT_W'(c - CH_0);
    end else if (c inside {[CH_LA:CH_LF]}) begin
      d = DIGIT_W'(c - CH_LA + 8'd10);
    end else if (c inside {[CH_UA:CH_UF]}) begin
      d = DIGIT_W'(c - CH_UA + 8'd10);
    end else begin
      d = NO_DIGIT;
    end
    return d;
  endfunction

  function automatic mode_t norm_mode(input logic [MODE_W-1:0] m);
    mode_t r;
    case (m)
      MODE_I:  r = MODE_I;
      MODE_O:  r = MODE_O;
      MODE_U:  r = MODE_U;
      MODE_X:  r = MODE_X;
      default: r = MODE_D;
    endcase
    return r;
  endfunction

  function automatic base_t base_of(input mode_t m);
    base_t b;
    case (m)
      MODE_O:  b = BASE_8;
      MODE_X:  b = BASE_16;
      default: b = BASE_10;
    endcase
    return b;
  endfunction

  function automatic logic [DIGIT_W-1:0] base_value(input base_t b);
    logic [DIGIT_W-1:0] v;
    case (b)
      BASE_8:  v = 5'd8;
      BASE_16: v = 5'd16;
      default: v = 5'd10;
    endcase
    return v;
  endfunction

endpackage

// ===== src/sfis_step.sv =====
// Next-state and result logic for one offered character or end mark.
// Depends on sfis_pkg; purely combinational, registered by the top level.
`timescale 1ns / 1ps

module sfis_step #(
  parameter int VALUE_BITS      = sfis_pkg::VALUE_BITS_DEF,
  parameter int MAX_FIELD_WIDTH = sfis_pkg::MAX_FIELD_WIDTH_DEF,
  parameter int RW_W            = $clog2(MAX_FIELD_WIDTH + 1)
) (
  input  sfis_pkg::ctl_t                     ctl_i,
  input  logic [VALUE_BITS-1:0]              mag_i,
  input  logic [RW_W-1:0]                    rem_i,
  input  logic                               eof_i,
  input  logic [sfis_pkg::CHAR_W-1:0]        char_i,
  input  logic [sfis_pkg::MODE_W-1:0]        cfg_mode_i,
  input  logic [sfis_pkg::FWIDTH_W-1:0]      cfg_width_i,
  output sfis_pkg::ctl_t                     ctl_o,
  output logic [VALUE_BITS-1:0]              mag_o,
  output logic [RW_W-1:0]                    rem_o,
  output sfis_pkg::res_flags_t               flags_o,
  output logic [sfis_pkg::VALUE_W-1:0]       value_o
);

  localparam int AW    = VALUE_BITS + 4;
  localparam int CMP_W = (RW_W > sfis_pkg::FWIDTH_W) ? RW_W : sfis_pkg::FWIDTH_W;
  localparam logic [sfis_pkg::VALUE_W-1:0] HALF =
    sfis_pkg::VALUE_W'(1) << (VALUE_BITS - 1);
  localparam logic [sfis_pkg::VALUE_W-1:0] UMAX = (HALF << 1) - sfis_pkg::VALUE_W'(1);

  sfis_pkg::ctl_t             c;
  logic [VALUE_BITS-1:0]      mag;
  logic [RW_W-1:0]            rem;
  logic                       handled;
  logic                       take;
  logic                       finish;
  sfis_pkg::status_t          fstat;
  logic                       consumed;
  logic [sfis_pkg::DIGIT_W-1:0] d;
  logic                       dig_ok;
  logic [AW-1:0]              m_ext;
  logic [AW-1:0]              prod;
  logic [AW-1:0]              acc;
  logic [CMP_W-1:0]           fw_ext;
  logic [CMP_W-1:0]           max_ext;
  logic [sfis_pkg::VALUE_W-1:0] m64;
  logic [sfis_pkg::VALUE_W-1:0] val;
  logic                       range;

  assign fw_ext  = CMP_W'(cfg_width_i);
  assign max_ext = CMP_W'(MAX_FIELD_WIDTH);

  always_comb begin
    c        = ctl_i;
    mag      = mag_i;
    rem      = rem_i;
    handled  = 1'b0;
    take     = 1'b0;
    finish   = 1'b0;
    fstat    = sfis_pkg::ST_OK;
    consumed = 1'b0;

    if (c.phase == sfis_pkg::PH_SPACE) begin
      if (eof_i) begin
        finish  = 1'b1;
        fstat   = sfis_pkg::ST_INPUT;
        handled = 1'b1;
      end else if (sfis_pkg::is_blank(char_i)) begin
        consumed = 1'b1;
        handled  = 1'b1;
      end else begin
        c.mode       = sfis_pkg::norm_mode(cfg_mode_i);
        c.base       = sfis_pkg::base_of(c.mode);
        rem          = (fw_ext > max_ext) ? RW_W'(max_ext) : RW_W'(fw_ext);
        c.negative   = 1'b0;
        c.overflowed = 1'b0;
        c.has_digit  = 1'b0;
        mag          = '0;
        c.phase      = sfis_pkg::PH_LEAD;
        if (char_i == sfis_pkg::CH_PLUS || char_i == sfis_pkg::CH_MINUS) begin
          c.negative = (char_i == sfis_pkg::CH_MINUS);
          consumed   = 1'b1;
          take       = 1'b1;
          fstat      = sfis_pkg::ST_MATCH;
          handled    = 1'b1;
        end
      end
    end

    if (!handled && c.phase == sfis_pkg::PH_LEAD) begin
      if (!eof_i && char_i == sfis_pkg::CH_0 &&
          (c.mode == sfis_pkg::MODE_I || c.base == sfis_pkg::BASE_16)) begin
        consumed    = 1'b1;
        c.has_digit = 1'b1;
        c.phase     = sfis_pkg::PH_ZERO;
        take        = 1'b1;
        fstat       = sfis_pkg::ST_OK;
        handled     = 1'b1;
      end else begin
        if (c.mode == sfis_pkg::MODE_I) c.base = sfis_pkg::BASE_10;
        c.phase = sfis_pkg::PH_DIGITS;
      end
    end

    if (!handled && c.phase == sfis_pkg::PH_ZERO) begin
      if (!eof_i && (char_i == sfis_pkg::CH_LX || char_i == sfis_pkg::CH_UX)) begin
        consumed    = 1'b1;
        c.base      = sfis_pkg::BASE_16;
        c.has_digit = 1'b0;
        c.phase     = sfis_pkg::PH_DIGITS;
        take        = 1'b1;
        fstat       = sfis_pkg::ST_MATCH;
        handled     = 1'b1;
      end else begin
        if (c.mode == sfis_pkg::MODE_I) c.base = sfis_pkg::BASE_8;
        c.phase = sfis_pkg::PH_DIGITS;
      end
    end

    d      = sfis_pkg::digit_of(char_i);
    dig_ok = !eof_i && (d < sfis_pkg::base_value(c.base));
    m_ext  = AW'(mag);
    case (c.base)
      sfis_pkg::BASE_8:  prod = m_ext << 3;
      sfis_pkg::BASE_16: prod = m_ext << 4;
      default:           prod = (m_ext << 3) + (m_ext << 1);
    endcase
    acc = prod + AW'(d);

    if (!handled) begin
      if (dig_ok) begin
        consumed    = 1'b1;
        c.has_digit = 1'b1;
        if (!c.overflowed) begin
          if (|acc[AW-1:VALUE_BITS]) c.overflowed = 1'b1;
          else mag = acc[VALUE_BITS-1:0];
        end
        take  = 1'b1;
        fstat = sfis_pkg::ST_OK;
      end else begin
        finish = 1'b1;
        fstat  = c.has_digit ? sfis_pkg::ST_OK : sfis_pkg::ST_MATCH;
      end
    end

    if (take && rem != '0) begin
      rem = rem - RW_W'(1);
      if (rem == '0) finish = 1'b1;
    end

    m64                   = '0;
    m64[VALUE_BITS-1:0]   = mag;
    val                   = '0;
    range                 = 1'b0;
    if (finish && fstat == sfis_pkg::ST_OK) begin
      if (c.mode == sfis_pkg::MODE_D || c.mode == sfis_pkg::MODE_I) begin
        if (c.negative) begin
          if (c.overflowed || m64 > HALF) begin
            range = 1'b1;
            val   = '0 - HALF;
          end else begin
            val = '0 - m64;
          end
        end else begin
          if (c.overflowed || m64 > HALF - sfis_pkg::VALUE_W'(1)) begin
            range = 1'b1;
            val   = HALF - sfis_pkg::VALUE_W'(1);
          end else begin
            val = m64;
          end
        end
      end else begin
        if (c.overflowed) begin
          range = 1'b1;
          val   = UMAX;
        end else begin
          val = c.negative ? (('0 - m64) & UMAX) : m64;
        end
      end
    end

    flags_o.consumed     = consumed;
    flags_o.done         = finish;
    flags_o.status       = finish ? fstat : sfis_pkg::ST_OK;
    flags_o.out_of_range = range;
    value_o              = val;

    if (finish) begin
      ctl_o = sfis_pkg::CTL_RESET;
      mag_o = '0;
      rem_o = '0;
    end else begin
      ctl_o = c;
      mag_o = mag;
      rem_o = rem;
    end
  end

endmodule

// ===== src/scanf_integer_field_scanner.sv =====
// A character word accepted into the input register passes through sfis_step into the output register.
// Throughput: one word per cycle unless out_stall holds a result; the field state loop (one multiply-add by the
// base and the saturation check) is combinational between the field state registers.
// Reset: synchronous, active low; clears the field state, both pipeline valids,
// and sets conversion mode to signed decimal with no width limit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scanf_integer_field_scanner #(
  parameter int VALUE_BITS      = sfis_pkg::VALUE_BITS_DEF,
  parameter int MAX_FIELD_WIDTH = sfis_pkg::MAX_FIELD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfis_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [sfis_pkg::CHAR_W-1:0]         in_character,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_consumed,
  output logic                                out_done_res,
  output logic [1:0]                          out_status,
  output logic [sfis_pkg::VALUE_W-1:0]        out_value,
  output logic                                out_out_of_range
);

  localparam int RW_W = $clog2(MAX_FIELD_WIDTH + 1);

  logic [sfis_pkg::MODE_W-1:0]   cfg_mode_r;
  logic [sfis_pkg::FWIDTH_W-1:0] cfg_width_r;

  logic                          in_v_r;
  logic                          in_kind_r;
  logic [sfis_pkg::CHAR_W-1:0]   in_char_r;

  sfis_pkg::ctl_t                ctl_r;
  sfis_pkg::ctl_t                ctl_nxt;
  logic [VALUE_BITS-1:0]         mag_r;
  logic [VALUE_BITS-1:0]         mag_nxt;
  logic [RW_W-1:0]               rem_r;
  logic [RW_W-1:0]               rem_nxt;

  sfis_pkg::res_flags_t          flags_nxt;
  logic [sfis_pkg::VALUE_W-1:0]  value_nxt;
  logic                          out_v_r;
  sfis_pkg::res_flags_t          out_flags_r;
  logic [sfis_pkg::VALUE_W-1:0]  out_value_r;

  logic                          res_load;
  logic                          in_take;

  assign cfg_ready = 1'b1;
  assign res_load  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && !res_load;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r  <= sfis_pkg::MODE_D;
      cfg_width_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfis_pkg::REG_MODE:  cfg_mode_r  <= cfg_data[sfis_pkg::MODE_W-1:0];
        sfis_pkg::REG_WIDTH: cfg_width_r <= cfg_data[sfis_pkg::FWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  sfis_step #(
    .VALUE_BITS      (VALUE_BITS),
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH),
    .RW_W            (RW_W)
  ) u_step (
    .ctl_i       (ctl_r),
    .mag_i       (mag_r),
    .rem_i       (rem_r),
    .eof_i       (in_kind_r),
    .char_i      (in_char_r),
    .cfg_mode_i  (cfg_mode_r),
    .cfg_width_i (cfg_width_r),
    .ctl_o       (ctl_nxt),
    .mag_o       (mag_nxt),
    .rem_o       (rem_nxt),
    .flags_o     (flags_nxt),
    .value_o     (value_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      ctl_r   <= sfis_pkg::CTL_RESET;
      mag_r   <= '0;
      rem_r   <= '0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (res_load) begin
        in_v_r <= 1'b0;
      end
      if (res_load) begin
        out_v_r <= 1'b1;
        ctl_r   <= ctl_nxt;
        mag_r   <= mag_nxt;
        rem_r   <= rem_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_kind_r <= in_kind;
      in_char_r <= in_character;
    end
    if (res_load) begin
      out_flags_r <= flags_nxt;
      out_value_r <= value_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_consumed     = out_flags_r.consumed;
  assign out_done_res     = out_flags_r.done;
  assign out_status       = out_flags_r.status;
  assign out_value        = out_value_r;
  assign out_out_of_range = out_flags_r.out_of_range;

  `ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_v_r && out_stall, "input stalled without a held result")
  `ASSERT_NEXT(a_done_clears, clk, rst_n, res_load && flags_nxt.done, ctl_r.phase == sfis_pkg::PH_SPACE && rem_r == '0 && mag_r == '0, "field state not cleared after done")
  `ASSERT_IMPL(a_fail_zero, clk, rst_n, out_v_r && out_status != sfis_pkg::ST_OK, out_value == '0 && !out_out_of_range && out_done_res, "failure word carries a value")
  `ASSERT_IMPL(a_refuse_ends, clk, rst_n, out_v_r && !out_consumed, out_done_res, "refused character did not end the field")
  `ASSERT_IMPL(a_rem_bound, clk, rst_n, 1'b1, rem_r <= RW_W'(MAX_FIELD_WIDTH), "remaining width beyond limit")

endmodule

// ===== dv/integer_field_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the integer field scanner: tracks register writes and input words,
// predicts the result word of each and compares the result channel field by field.
// Depends on sfis_pkg only.

module integer_field_checker
  import sfis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_kind,
  input  logic [CHAR_W-1:0]     in_character,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_consumed,
  input  logic                  out_done_res,
  input  logic [1:0]            out_status,
  input  logic [VALUE_W-1:0]    out_value,
  input  logic                  out_out_of_range,
  output int                    fail_count,
  output int                    pending_count
);

  localparam logic [VALUE_W-1:0] ALL_ONES = '1;
  localparam logic [VALUE_W-1:0] MIN_NEG  = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] MAX_POS  = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic               consumed;
    logic               done;
    status_t            status;
    logic [VALUE_W-1:0] value;
    logic               out_of_range;
  } scan_result_t;

  logic [MODE_W-1:0]   mode_reg;
  logic [FWIDTH_W-1:0] width_reg;

  phase_t              fld_phase;
  mode_t               fld_mode;
  int unsigned         fld_radix;
  logic                fld_negative;
  logic [VALUE_W-1:0]  fld_magnitude;
  logic                fld_overflow;
  logic [FWIDTH_W-1:0] fld_left;
  logic                fld_has_digit;

  scan_result_t scan_results_q[$];

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int unsigned digit_weight(input logic [CHAR_W-1:0] c);
    if (c >= CH_0 && c <= CH_9) return 32'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return 32'(c - CH_LA) + 32'd10;
    if (c >= CH_UA && c <= CH_UF) return 32'(c - CH_UA) + 32'd10;
    return 16;
  endfunction

  function automatic void restart_field();
    fld_phase     = PH_SPACE;
    fld_mode      = MODE_D;
    fld_radix     = 10;
    fld_negative  = 1'b0;
    fld_magnitude = '0;
    fld_overflow  = 1'b0;
    fld_left      = '0;
    fld_has_digit = 1'b0;
  endfunction

  // count one field character; true once the width runs out
  function automatic logic count_taken();
    if (fld_left != '0) begin
      fld_left = fld_left - FWIDTH_W'(1);
      return fld_left == '0;
    end
    return 1'b0;
  endfunction

  function automatic scan_result_t close_field(input status_t st, input logic took);
    scan_result_t r;
    r          = '0;
    r.consumed = took;
    r.done     = 1'b1;
    r.status   = st;
    if (st == ST_OK) begin
      if (fld_mode == MODE_D || fld_mode == MODE_I) begin
        if (fld_negative) begin
          if (fld_overflow || fld_magnitude > MIN_NEG) begin
            r.out_of_range = 1'b1;
            r.value        = MIN_NEG;
          end else begin
            r.value = '0 - fld_magnitude;
          end
        end else if (fld_overflow || fld_magnitude > MAX_POS) begin
          r.out_of_range = 1'b1;
          r.value        = MAX_POS;
        end else begin
          r.value = fld_magnitude;
        end
      end else if (fld_overflow) begin
        r.out_of_range = 1'b1;
        r.value        = ALL_ONES;
      end else if (fld_negative) begin
        r.value = '0 - fld_magnitude;
      end else begin
        r.value = fld_magnitude;
      end
    end
    restart_field();
    return r;
  endfunction

  function automatic scan_result_t scan_word(input logic eoi, input logic [CHAR_W-1:0] c);
    scan_result_t       r;
    int unsigned        d;
    logic [VALUE_W-1:0] lim;
    r = '0;
    if (fld_phase == PH_SPACE) begin
      if (eoi) return close_field(ST_INPUT, 1'b0);
      if (is_space(c)) begin
        r.consumed = 1'b1;
        return r;
      end
      // latch mode and width on the first field character
      if (mode_reg > MODE_X) begin
        fld_mode = MODE_D;
      end else begin
        fld_mode = mode_t'(mode_reg);
      end
      if (fld_mode == MODE_O) begin
        fld_radix = 8;
      end else if (fld_mode == MODE_X) begin
        fld_radix = 16;
      end else begin
        fld_radix = 10;
      end
      fld_left      = width_reg;
      fld_negative  = 1'b0;
      fld_magnitude = '0;
      fld_overflow  = 1'b0;
      fld_has_digit = 1'b0;
      fld_phase     = PH_LEAD;
      if (c == CH_PLUS || c == CH_MINUS) begin
        fld_negative = (c == CH_MINUS);
        r.consumed   = 1'b1;
        if (count_taken()) return close_field(ST_MATCH, 1'b1);
        return r;
      end
    end
    if (fld_phase == PH_LEAD) begin
      if (!eoi && c == CH_0 && (fld_mode == MODE_I || fld_radix == 16)) begin
        r.consumed    = 1'b1;
        fld_has_digit = 1'b1;
        fld_phase     = PH_ZERO;
        if (count_taken()) return close_field(ST_OK, 1'b1);
        return r;
      end
      if (fld_mode == MODE_I) fld_radix = 10;
      fld_phase = PH_DIGITS;
    end
    if (fld_phase == PH_ZERO) begin
      if (!eoi && (c == CH_LX || c == CH_UX)) begin
        r.consumed    = 1'b1;
        fld_radix     = 16;
        fld_has_digit = 1'b0;
        fld_phase     = PH_DIGITS;
        if (count_taken()) return close_field(ST_MATCH, 1'b1);
        return r;
      end
      if (fld_mode == MODE_I) fld_radix = 8;
      fld_phase = PH_DIGITS;
    end
    d = eoi ? 16 : digit_weight(c);
    if (d < fld_radix) begin
      r.consumed    = 1'b1;
      fld_has_digit = 1'b1;
      if (!fld_overflow) begin
        lim = (ALL_ONES - VALUE_W'(d)) / VALUE_W'(fld_radix);
        if (fld_magnitude > lim) begin
          fld_overflow = 1'b1;
        end else begin
          fld_magnitude = fld_magnitude * VALUE_W'(fld_radix) + VALUE_W'(d);
        end
      end
      if (count_taken()) return close_field(ST_OK, 1'b1);
      return r;
    end
    if (fld_has_digit) return close_field(ST_OK, 1'b0);
    return close_field(ST_MATCH, 1'b0);
  endfunction

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst_n) begin
      mode_reg      = MODE_D;
      width_reg     = '0;
      restart_field();
      scan_results_q.delete();
      fail_count    = 0;
      pending_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (scan_results_q.size() == 0) begin
          report_mismatch("result word with nothing expected", out_value, '0);
        end else begin
          want = scan_results_q.pop_front();
          if (out_consumed !== want.consumed)
            report_mismatch("consumed", VALUE_W'(out_consumed), VALUE_W'(want.consumed));
          if (out_done_res !== want.done)
            report_mismatch("done_res", VALUE_W'(out_done_res), VALUE_W'(want.done));
          if (out_status !== want.status)
            report_mismatch("status", VALUE_W'(out_status), VALUE_W'(want.status));
          if (out_value !== want.value)
            report_mismatch("value", out_value, want.value);
          if (out_out_of_range !== want.out_of_range)
            report_mismatch("out_of_range", VALUE_W'(out_out_of_range),
                            VALUE_W'(want.out_of_range));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODE) begin
          mode_reg = cfg_data[MODE_W-1:0];
        end else if (cfg_index == REG_WIDTH) begin
          width_reg = cfg_data[FWIDTH_W-1:0];
        end
      end
      if (in_valid && !in_stall) scan_results_q.push_back(scan_word(in_kind, in_character));
      pending_count = scan_results_q.size();
    end
  end

endmodule

// ===== dv/tb_scanf_integer_field_scanner.sv =====
`timescale 1ns / 1ps
// Top of the integer field scanner bench: clock, reset, register writes, character
// words with random gaps and result stalls, and the final verdict.
// Depends on sfis_pkg, the scanner RTL and integer_field_checker.

module tb_scanf_integer_field_scanner;
  import sfis_pkg::*;

  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_WORDS = 1050;
  localparam int QUIET_FROM   = 850;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_kind      = 1'b0;
  logic [CHAR_W-1:0]     in_character = '0;
  logic                  out_stall    = 1'b0;

  logic                  cfg_ready;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_consumed;
  logic                  out_done_res;
  logic [1:0]            out_status;
  logic [VALUE_W-1:0]    out_value;
  logic                  out_out_of_range;

  int                    fail_count;
  int                    pending_count;

  logic                  idle_on   = 1'b1;
  logic                  long_hold = 1'b0;
  logic [MODE_W-1:0]     cur_mode  = '0;
  int                    words_sent = 0;

  always #10 clk = ~clk;

  scanf_integer_field_scanner DUT (.*);

  integer_field_checker u_checker (.*);

  task automatic send_word(input logic eoi, input logic [CHAR_W-1:0] c);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= eoi;
    in_character <= c;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] mode_word,
                            input logic [FWIDTH_W-1:0] width);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= mode_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_WIDTH;
    cfg_data  <= width;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = mode_word[MODE_W-1:0];
  endtask

  task automatic send_random_field();
    int unsigned radix;
    int unsigned ndig;
    int unsigned v;
    int unsigned k;
    if ($urandom_range(0, 9) < 2) begin
      // noise: arbitrary bytes and end marks
      repeat ($urandom_range(1, 4)) send_word($urandom_range(0, 7) == 0, CHAR_W'($urandom));
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      k = $urandom_range(0, 5);
      send_word(1'b0, (k == 5) ? CH_SPACE : CHAR_W'(CH_TAB + k));
    end
    case ($urandom_range(0, 3))
      0:       send_word(1'b0, CH_PLUS);
      1:       send_word(1'b0, CH_MINUS);
      default: ;
    endcase
    if (cur_mode == MODE_O) begin
      radix = 8;
    end else if (cur_mode == MODE_X) begin
      radix = 16;
    end else begin
      radix = 10;
    end
    if ((cur_mode == MODE_X || cur_mode == MODE_I) && $urandom_range(0, 2) == 0) begin
      send_word(1'b0, CH_0);
      send_word(1'b0, $urandom_range(0, 1) ? CH_LX : CH_UX);
      radix = 16;
    end else if (cur_mode == MODE_I && $urandom_range(0, 3) == 0) begin
      send_word(1'b0, CH_0);
      radix = 8;
    end
    ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 6);
    repeat (ndig) begin
      v = $urandom_range(0, radix - 1);
      if (v < 10) begin
        send_word(1'b0, CHAR_W'(CH_0 + v));
      end else begin
        send_word(1'b0, CHAR_W'(($urandom_range(0, 1) ? CH_LA : CH_UA) + v - 10));
      end
    end
    case ($urandom_range(0, 3))
      0:       send_word(1'b1, CHAR_W'($urandom));
      1:       send_word(1'b0, CH_SPACE);
      2:       send_word(1'b0, CHAR_W'($urandom));
      default: ;
    endcase
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int                    start;
    int                    phase_no;
    logic [CFG_DATA_W-1:0] mode_word;
    logic [FWIDTH_W-1:0]   width;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(CFG_DATA_W'(MODE_D), '0);
    send_text(" \t-42 ");
    send_word(1'b1, 8'hFF);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h00);
    send_text("+z");
    drain();
    set_config(CFG_DATA_W'(MODE_X), '0);
    send_text("0xg-0XfF,");
    drain();
    set_config(CFG_DATA_W'(MODE_I), '0);
    send_text("0x1A;017 0 9");
    send_word(1'b1, 8'h00);
    drain();
    set_config(CFG_DATA_W'(MODE_O), '0);
    send_text("778 ");
    drain();
    set_config(CFG_DATA_W'(MODE_U), '0);
    send_text("-1 99999999999999999999 ");
    drain();
    set_config(CFG_DATA_W'(5), 10'd1);
    send_text("+5");
    drain();
    set_config(CFG_DATA_W'(7), 10'd3);
    send_text("-12345 ");
    drain();
    set_config(CFG_DATA_W'(6), '1);
    send_text("-9223372036854775808 9223372036854775808 ");
    drain();
    // change the registers inside an open field
    set_config(CFG_DATA_W'(MODE_D), '0);
    send_text("  1");
    drain();
    set_config(CFG_DATA_W'(MODE_X), 10'd2);
    send_text("9f fff");
    send_word(1'b1, 8'h00);

    start    = words_sent;
    phase_no = 0;
    while (words_sent - start < RANDOM_WORDS) begin
      drain();
      mode_word           = CFG_DATA_W'($urandom);
      mode_word[2:0]      = MODE_W'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0:       width = '0;
        1:       width = '1;
        2:       width = FWIDTH_W'($urandom);
        default: width = FWIDTH_W'($urandom_range(1, 24));
      endcase
      set_config(mode_word, width);
      idle_on = (words_sent - start < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if (phase_no == 2) long_hold = 1'b1;
      repeat ($urandom_range(3, 25)) send_random_field();
      phase_no++;
    end
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/sfis_pkg.sv
src/sfis_step.sv
src/scanf_integer_field_scanner.sv
dv/integer_field_checker.sv
dv/tb_scanf_integer_field_scanner.sv
